// File: hdl/lnsc_pkg.sv
// Shared types and constants for the letterbox nearest-neighbor scaler.
package lnsc_pkg;

   localparam int CSR_W   = 12;
   localparam int COORD_W = 11;
   localparam int IDX_W   = 16;
   localparam int PIX_W   = 32;
   localparam int PROD_W  = 23;
   localparam int QUO_W   = 12;
   localparam int ADDR_W  = 24;
   localparam int NDIV    = 12;
   localparam int NSTAGE  = NDIV + 3;
   localparam int QDEPTH  = 32;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_LAYER_SIZE = 3'd2,
      CSR_FIT_WIDTH  = 3'd3,
      CSR_FIT_HEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_READ  = 1'b1
   } func_type;

   // one operation handed from the front pipeline to the store side
   typedef struct packed {
      func_type            func;
      logic                hit;
      logic                ins;
      logic [ADDR_W-1:0]   addr;
      logic [PIX_W-1:0]    data;
   } op_type;

   // one stage of the front pipeline; axis 0 is x, axis 1 is y
   typedef struct packed {
      logic                    vld;
      func_type                func;
      logic [IDX_W-1:0]        idx;
      logic [PIX_W-1:0]        data;
      logic                    ins;
      logic [1:0][PROD_W-1:0]  rem;
      logic [1:0][QUO_W-1:0]   quo;
      logic [ADDR_W-1:0]       addr;
   } front_stage_type;

   // one restoring-division step on both axes, quotient bit NDIV-1-j
   function automatic front_stage_type div_step(input front_stage_type s,
                                                input logic [1:0][QUO_W-1:0] f,
                                                input int j);
      front_stage_type   r;
      logic [PROD_W-1:0] dvs;
      r = s;
      for (int a = 0; a < 2; a++) begin
         dvs = {f[a], {(PROD_W-QUO_W){1'b0}}} >> j;
         if (s.rem[a] >= dvs) begin
            r.rem[a] = s.rem[a] - dvs;
            r.quo[a][NDIV-1-j] = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

// File: hdl/lnsc_ram.sv
// Generic simple dual-port RAM with registered read.
module lnsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lnsc_front.sv
// Front pipeline: config registers, fit test, scale multiply, division, address.
module lnsc_front #(
   parameter int SRC_PIXELS = 65536,
   parameter int MAX_EDGE   = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [lnsc_pkg::IDX_W-1:0]   req_pixel_index,
   input  logic [lnsc_pkg::PIX_W-1:0]   req_pixel_data,
   input  logic [lnsc_pkg::COORD_W-1:0] req_layer_x,
   input  logic [lnsc_pkg::COORD_W-1:0] req_layer_y,
   input  logic                         csr_valid,
   input  logic [2:0]                   csr_index,
   input  logic [lnsc_pkg::CSR_W-1:0]   csr_data,
   input  logic                         pop,
   output logic                         push,
   output lnsc_pkg::op_type             push_op
);

   localparam logic [12:0] EDGE_CAP = 13'(MAX_EDGE);
   localparam logic [lnsc_pkg::ADDR_W:0] SRC_LIM = (lnsc_pkg::ADDR_W+1)'(SRC_PIXELS);

   logic [lnsc_pkg::CSR_W-1:0] src_width_ff, src_height_ff, layer_size_ff;
   logic [lnsc_pkg::CSR_W-1:0] fit_width_ff, fit_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 12'd1;
         src_height_ff <= 12'd1;
         layer_size_ff <= 12'd64;
         fit_width_ff  <= 12'd64;
         fit_height_ff <= 12'd64;
      end else if (csr_valid) begin
         unique case (lnsc_pkg::csr_index_type'(csr_index))
            lnsc_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_data;
            lnsc_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_data;
            lnsc_pkg::CSR_LAYER_SIZE: layer_size_ff <= csr_data;
            lnsc_pkg::CSR_FIT_WIDTH:  fit_width_ff  <= csr_data;
            lnsc_pkg::CSR_FIT_HEIGHT: fit_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [12:0]                               edge_w;
   logic [1:0][lnsc_pkg::QUO_W-1:0]           fit_raw, fsz, src_eff;
   logic [1:0][lnsc_pkg::QUO_W-1:0]           off;
   logic [1:0][lnsc_pkg::COORD_W-1:0]         crd, u;
   logic [1:0]                                in_ax;

   always_comb begin
      edge_w = ({1'b0, layer_size_ff} < EDGE_CAP) ? {1'b0, layer_size_ff} : EDGE_CAP;
      fit_raw[0] = fit_width_ff;
      fit_raw[1] = fit_height_ff;
      src_eff[0] = (src_width_ff != '0) ? src_width_ff : 12'd1;
      src_eff[1] = (src_height_ff != '0) ? src_height_ff : 12'd1;
      crd[0] = req_layer_x;
      crd[1] = req_layer_y;
      for (int a = 0; a < 2; a++) begin
         fsz[a] = ({1'b0, fit_raw[a]} < edge_w) ? fit_raw[a] : edge_w[11:0];
         off[a] = 12'((edge_w - {1'b0, fsz[a]}) >> 1);
         in_ax[a] = (fsz[a] != '0) && ({2'b0, crd[a]} >= {1'b0, off[a]}) &&
                    ({2'b0, crd[a]} < ({1'b0, off[a]} + {1'b0, fsz[a]}));
         u[a] = 11'({2'b0, crd[a]} - {1'b0, off[a]});
      end
   end

   logic accept;
   logic [lnsc_pkg::QCNT_W-1:0] occ_ff, occ_in;

   assign accept    = req_valid && !req_stall;
   // beats accepted but not yet drained from the queue
   assign req_stall = (occ_ff >= lnsc_pkg::QCNT_W'(lnsc_pkg::QDEPTH));
   assign occ_in    = occ_ff + lnsc_pkg::QCNT_W'(accept) - lnsc_pkg::QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   lnsc_pkg::front_stage_type pipe_ff [lnsc_pkg::NSTAGE];
   lnsc_pkg::front_stage_type pipe_in [lnsc_pkg::NSTAGE];

   always_comb begin
      pipe_in[0]      = '0;
      pipe_in[0].vld  = accept;
      pipe_in[0].func = lnsc_pkg::func_type'(req_func);
      pipe_in[0].idx  = req_pixel_index;
      pipe_in[0].data = req_pixel_data;
      pipe_in[0].ins  = in_ax[0] && in_ax[1];
      for (int a = 0; a < 2; a++) begin
         pipe_in[0].rem[a] = {12'b0, u[a]};
      end
   end

   always_comb begin
      pipe_in[1] = pipe_ff[0];
      for (int a = 0; a < 2; a++) begin
         pipe_in[1].rem[a] = {12'b0, pipe_ff[0].rem[a][10:0]} * {11'b0, src_eff[a]};
      end
   end

   for (genvar j = 0; j < lnsc_pkg::NDIV; j++) begin : g_div
      assign pipe_in[j+2] = lnsc_pkg::div_step(pipe_ff[j+1], fsz, j);
   end

   always_comb begin
      pipe_in[lnsc_pkg::NSTAGE-1]      = pipe_ff[lnsc_pkg::NSTAGE-2];
      pipe_in[lnsc_pkg::NSTAGE-1].addr =
         {12'b0, pipe_ff[lnsc_pkg::NSTAGE-2].quo[1]} * {12'b0, src_eff[0]} +
         {12'b0, pipe_ff[lnsc_pkg::NSTAGE-2].quo[0]};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < lnsc_pkg::NSTAGE; i++) begin
         if (reset) begin
            pipe_ff[i] <= '0;
         end else begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   lnsc_pkg::front_stage_type last;

   always_comb begin
      last         = pipe_ff[lnsc_pkg::NSTAGE-1];
      push         = last.vld;
      push_op.func = last.func;
      push_op.data = last.data;
      if (last.func == lnsc_pkg::FUNC_WRITE) begin
         push_op.addr = {8'b0, last.idx};
         push_op.ins  = 1'b0;
         push_op.hit  = ({9'b0, last.idx} < SRC_LIM);
      end else begin
         push_op.addr = last.addr;
         push_op.ins  = last.ins;
         push_op.hit  = last.ins && ({1'b0, last.addr} < SRC_LIM);
      end
   end

endmodule

// File: hdl/lnsc_queue.sv
// Short queue of operations between the front pipeline and the store side.
module lnsc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lnsc_pkg::op_type push_op,
   input  logic             pop,
   output logic             empty,
   output lnsc_pkg::op_type head
);

   lnsc_pkg::op_type mem_ff [lnsc_pkg::QDEPTH];
   logic [lnsc_pkg::QPTR_W-1:0] wptr_ff, rptr_ff;
   logic [lnsc_pkg::QCNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + lnsc_pkg::QCNT_W'(push) - lnsc_pkg::QCNT_W'(pop);
      end
   end

   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rptr_ff];

endmodule

// File: hdl/lnsc_back.sv
// Store side: pixel memory access and the result register.
module lnsc_back #(
   parameter int SRC_PIXELS = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       empty,
   input  lnsc_pkg::op_type           head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lnsc_pkg::PIX_W-1:0] rsp_layer_pixel,
   output logic                       rsp_inside_fit
);

   localparam int AW = $clog2(SRC_PIXELS);

   logic s1_vld_ff, s1_vld_in, s1_hit_ff, s1_ins_ff;
   logic out_vld_ff, out_vld_in, out_ins_ff;
   logic [lnsc_pkg::PIX_W-1:0] out_pix_ff, rd_data;
   logic take, s1_move, s1_free, is_read, wr_en, rd_en;

   assign is_read = (head.func == lnsc_pkg::FUNC_READ);
   assign take    = out_vld_ff && !rsp_stall;
   assign s1_move = s1_vld_ff && (!out_vld_ff || take);
   assign s1_free = !s1_vld_ff || s1_move;
   // writes drain freely; a read needs room in the read stage
   assign pop     = !empty && (!is_read || s1_free);
   assign wr_en   = pop && !is_read && head.hit;
   assign rd_en   = pop && is_read;

   lnsc_ram #(
      .WIDTH (lnsc_pkg::PIX_W),
      .DEPTH (SRC_PIXELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head.addr[AW-1:0]),
      .wr_data (head.data),
      .rd_en   (rd_en),
      .rd_addr (head.addr[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_vld_in = rd_en || (s1_vld_ff && !s1_move);
      out_vld_in = s1_move || (out_vld_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_hit_ff <= head.hit;
         s1_ins_ff <= head.ins;
      end
      if (s1_move) begin
         out_pix_ff <= s1_hit_ff ? rd_data : '0;
         out_ins_ff <= s1_ins_ff;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_layer_pixel = out_pix_ff;
   assign rsp_inside_fit  = out_ins_ff;

endmodule

// File: hdl/letterbox_nearest_scaler_top.sv
// Letterbox nearest-neighbor scaler, top level.
// Takes one beat per clock while req_stall is low, writes and reads alike, and returns
// one result beat per read beat; write beats return nothing. A beat passes the front
// pipeline (fit test, scale multiply, a 12-stage one-bit-per-stage division for each
// axis, address multiply), then the queue, the pixel memory read and the result register.
// Up to 32 beats can be accepted and not yet drained by the store side; past that
// req_stall rises until the store side drains beats. The user must write configuration
// registers through the csr_ port only while no beat is in flight; the block does not
// enforce it. csr_ready is always high. The pixel store is not cleared by reset.
module letterbox_nearest_scaler_top #(
   parameter int SRC_PIXELS = 65536,
   parameter int MAX_EDGE   = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [lnsc_pkg::IDX_W-1:0]   req_pixel_index,
   input  logic [lnsc_pkg::PIX_W-1:0]   req_pixel_data,
   input  logic [lnsc_pkg::COORD_W-1:0] req_layer_x,
   input  logic [lnsc_pkg::COORD_W-1:0] req_layer_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lnsc_pkg::PIX_W-1:0]   rsp_layer_pixel,
   output logic                         rsp_inside_fit,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [lnsc_pkg::CSR_W-1:0]   csr_data
);

   logic             push, pop, empty;
   lnsc_pkg::op_type push_op, head;

   assign csr_ready = 1'b1;

   lnsc_front #(
      .SRC_PIXELS (SRC_PIXELS),
      .MAX_EDGE   (MAX_EDGE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_pixel_index (req_pixel_index),
      .req_pixel_data  (req_pixel_data),
      .req_layer_x     (req_layer_x),
      .req_layer_y     (req_layer_y),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .pop             (pop),
      .push            (push),
      .push_op         (push_op)
   );

   lnsc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .empty   (empty),
      .head    (head)
   );

   lnsc_back #(
      .SRC_PIXELS (SRC_PIXELS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_layer_pixel (rsp_layer_pixel),
      .rsp_inside_fit  (rsp_inside_fit)
   );

endmodule
